/* hdl/qlsf_pkg.sv */
// ----------------------------------------------------------------------------
// qlsf_pkg
// Shared widths, codes and types for the quadratic least-squares fit block.
// ----------------------------------------------------------------------------
package qlsf_pkg;

	localparam int ROW_BITS   = 10;
	localparam int COL_BITS   = 11;
	localparam int FRAC_BITS  = 24;
	localparam int MAX_POINTS = 65536;
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
	localparam int SUM_BITS   = 56;
	localparam int MOM_BITS   = 47;
	localparam int OUT_BITS   = 48;
	localparam int STAT_BITS  = 2;

	// exact determinant width: three sum-wide factors, six terms, sign, spare
	localparam int DW        = 3 * SUM_BITS + 9;
	localparam int DIV_STEPS = DW + FRAC_BITS;
	localparam int SCNT_W    = $clog2(DIV_STEPS);
	localparam int Q_W       = OUT_BITS + 1;

	localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_SING  = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_NOPTS = 2'd2;
	localparam logic [STAT_BITS-1:0] ST_DROP  = 2'd3;

	// permutation terms of the 3x3 determinant: column used by each row
	localparam int NTERMS = 6;
	localparam logic [1:0] PERM_COL [NTERMS][3] = '{
		'{2'd0, 2'd1, 2'd2},
		'{2'd0, 2'd2, 2'd1},
		'{2'd1, 2'd0, 2'd2},
		'{2'd1, 2'd2, 2'd0},
		'{2'd2, 2'd0, 2'd1},
		'{2'd2, 2'd1, 2'd0}
	};
	localparam logic [NTERMS-1:0] TERM_NEG = 6'b100110;

	typedef struct packed {
		logic [CNT_BITS-1:0]          cnt;
		logic [3:0][SUM_BITS-1:0]     pw;
		logic [2:0][MOM_BITS-1:0]     mom;
		logic [ROW_BITS-1:0]          first;
		logic [ROW_BITS-1:0]          latest;
		logic                         ovf;
		logic                         idle;
	} acc_sums_t;

	typedef enum logic [3:0] {
		SV_IDLE,
		SV_LD1,
		SV_MUL1,
		SV_LD2,
		SV_MUL2,
		SV_NEXT,
		SV_ABS,
		SV_DIV,
		SV_RND,
		SV_OUT
	} sv_state_t;

endpackage

/* hdl/qlsf_accum.sv */
// ----------------------------------------------------------------------------
// qlsf_accum
// Power sums of the row and column moments, one shared multiplier, 7 steps.
// ----------------------------------------------------------------------------
module qlsf_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [qlsf_pkg::ROW_BITS-1:0] row,
	input  logic [qlsf_pkg::COL_BITS-1:0] col,
	input  logic                          has_point,
	input  logic                          clear,
	output qlsf_pkg::acc_sums_t           sums
);
	import qlsf_pkg::*;

	logic [CNT_BITS-1:0]      cnt_q;
	logic [3:0][SUM_BITS-1:0] pw_q;
	logic [2:0][MOM_BITS-1:0] mom_q;
	logic [ROW_BITS-1:0]      first_q, latest_q, row_q;
	logic [COL_BITS-1:0]      col_q;
	logic                     ovf_q, run_q;
	logic [2:0]               step_q;
	logic [SUM_BITS-1:0]      p_q, prod, addend, sum;

	assign prod   = SUM_BITS'(p_q * row_q);
	assign addend = (step_q < 3'd4) ? pw_q[step_q[1:0]] : SUM_BITS'(mom_q[step_q[1:0]]);
	assign sum    = addend + p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pw_q     <= '0;
			mom_q    <= '0;
			first_q  <= '0;
			latest_q <= '0;
			ovf_q    <= 1'b0;
			run_q    <= 1'b0;
			step_q   <= '0;
		end else if (clear) begin
			cnt_q    <= '0;
			pw_q     <= '0;
			mom_q    <= '0;
			first_q  <= '0;
			latest_q <= '0;
			ovf_q    <= 1'b0;
		end else if (run_q) begin
			if (step_q < 3'd4) begin
				pw_q[step_q[1:0]] <= sum;
			end else begin
				mom_q[step_q[1:0]] <= sum[MOM_BITS-1:0];
			end
			// after the fourth power the column seeds the moments
			p_q    <= (step_q == 3'd3) ? SUM_BITS'(col_q) : prod;
			step_q <= step_q + 3'd1;
			if (step_q == 3'd6) begin
				run_q <= 1'b0;
			end
		end else if (take && has_point) begin
			if (cnt_q == CNT_BITS'(MAX_POINTS)) begin
				ovf_q <= 1'b1;
			end else begin
				row_q    <= row;
				col_q    <= col;
				p_q      <= SUM_BITS'(row);
				step_q   <= '0;
				run_q    <= 1'b1;
				latest_q <= row;
				if (cnt_q == '0) begin
					first_q <= row;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		sums.cnt    = cnt_q;
		sums.pw     = pw_q;
		sums.mom    = mom_q;
		sums.first  = first_q;
		sums.latest = latest_q;
		sums.ovf    = ovf_q;
		sums.idle   = !run_q;
	end

endmodule

/* hdl/qlsf_solve.sv */
// ----------------------------------------------------------------------------
// qlsf_solve
// Exact Cramer solve: bit-serial multiply, restoring divide, one wide adder.
// ----------------------------------------------------------------------------
module qlsf_solve (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  qlsf_pkg::acc_sums_t                 sums,
	output logic                                busy,
	output logic                                done,
	output logic                                clear,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef0,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef1,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef2,
	output logic [qlsf_pkg::ROW_BITS-1:0]       span_start,
	output logic [qlsf_pkg::ROW_BITS-1:0]       span_end,
	output logic [qlsf_pkg::STAT_BITS-1:0]      fit_status
);
	import qlsf_pkg::*;

	sv_state_t state_q, state_d;

	logic [DW-1:0]          acc_q, tmp_q, mc_q, dabs_q, num_q, rem_q;
	logic [SUM_BITS-1:0]    ml_q;
	logic                   dneg_q, nneg_q, sticky_q;
	logic [Q_W-1:0]         q_q;
	logic [1:0]             pass_q;
	logic [2:0]             term_q;
	logic [SCNT_W-1:0]      cnt_q;
	logic [OUT_BITS-1:0]    coef_q [3];
	logic [ROW_BITS-1:0]    lo_q, hi_q;
	logic [STAT_BITS-1:0]   status_q;

	logic [SUM_BITS-1:0]    s_arr [5];
	logic [SUM_BITS-1:0]    ent [3];
	logic [DW-1:0]          add_a, add_b, r2;
	logic                   add_sub;
	logic [DW:0]            add_y;
	logic [Q_W:0]           mag;
	logic                   sat;
	logic [OUT_BITS-1:0]    fin;
	logic                   last_mul, last_div;

	always_comb begin
		s_arr[0] = SUM_BITS'(sums.cnt);
		for (int k = 0; k < 4; k++) begin
			s_arr[k + 1] = sums.pw[k];
		end
		for (int i = 0; i < 3; i++) begin
			if (pass_q != 2'd0 && PERM_COL[term_q][i] == pass_q - 2'd1) begin
				ent[i] = SUM_BITS'(sums.mom[i]);
			end else begin
				ent[i] = s_arr[3'(i) + 3'(PERM_COL[term_q][i])];
			end
		end
	end

	assign r2 = {rem_q[DW-2:0], num_q[DW-1]};

	always_comb begin
		add_a   = tmp_q;
		add_b   = mc_q;
		add_sub = 1'b0;
		case (state_q)
			SV_MUL2: begin
				add_a   = acc_q;
				add_sub = TERM_NEG[term_q];
			end
			SV_ABS: begin
				add_a   = '0;
				add_b   = acc_q;
				add_sub = 1'b1;
			end
			SV_DIV: begin
				add_a   = r2;
				add_b   = dabs_q;
				add_sub = 1'b1;
			end
			SV_RND: begin
				add_a   = {rem_q[DW-2:0], 1'b0};
				add_b   = dabs_q;
				add_sub = 1'b1;
			end
			default: begin
				add_a = tmp_q;
			end
		endcase
	end

	// carry out of a subtract means a >= b
	assign add_y = {1'b0, add_a} + {1'b0, add_b ^ {DW{add_sub}}} + (DW + 1)'(add_sub);

	assign mag = {1'b0, q_q} + (Q_W + 1)'(add_y[DW]);
	assign sat = sticky_q | (|mag[Q_W:OUT_BITS-1]);
	always_comb begin
		if (nneg_q != dneg_q) begin
			fin = sat ? {1'b1, {(OUT_BITS-1){1'b0}}} : -mag[OUT_BITS-1:0];
		end else begin
			fin = sat ? {1'b0, {(OUT_BITS-1){1'b1}}} : mag[OUT_BITS-1:0];
		end
	end

	assign last_mul = (cnt_q == SCNT_W'(SUM_BITS - 1));
	assign last_div = (cnt_q == SCNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != SV_IDLE);
		done    = 1'b0;
		clear   = 1'b0;
		case (state_q)
			SV_IDLE: begin
				if (go) begin
					state_d = (sums.cnt == '0 || sums.ovf) ? SV_OUT : SV_LD1;
				end
			end
			SV_LD1:  state_d = SV_MUL1;
			SV_MUL1: if (last_mul) state_d = SV_LD2;
			SV_LD2:  state_d = SV_MUL2;
			SV_MUL2: if (last_mul) state_d = SV_NEXT;
			SV_NEXT: begin
				if (term_q != 3'(NTERMS - 1)) begin
					state_d = SV_LD1;
				end else if (pass_q == 2'd0 && acc_q == '0) begin
					state_d = SV_OUT;
				end else begin
					state_d = SV_ABS;
				end
			end
			SV_ABS:  state_d = (pass_q == 2'd0) ? SV_LD1 : SV_DIV;
			SV_DIV:  if (last_div) state_d = SV_RND;
			SV_RND:  state_d = (pass_q == 2'd3) ? SV_OUT : SV_LD1;
			SV_OUT: begin
				done    = 1'b1;
				clear   = 1'b1;
				state_d = SV_IDLE;
			end
			default: state_d = SV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q   <= '0;
			term_q   <= '0;
			cnt_q    <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				SV_IDLE: begin
					if (go) begin
						acc_q     <= '0;
						pass_q    <= '0;
						term_q    <= '0;
						coef_q[0] <= '0;
						coef_q[1] <= '0;
						coef_q[2] <= '0;
						lo_q      <= (sums.first < sums.latest) ? sums.first : sums.latest;
						hi_q      <= (sums.first < sums.latest) ? sums.latest : sums.first;
						if (sums.cnt == '0) begin
							status_q <= ST_NOPTS;
						end else if (sums.ovf) begin
							status_q <= ST_DROP;
						end else begin
							status_q <= ST_OK;
						end
					end
				end
				SV_LD1: begin
					mc_q  <= DW'(ent[0]);
					ml_q  <= ent[1];
					tmp_q <= '0;
					cnt_q <= '0;
				end
				SV_MUL1: begin
					if (ml_q[0]) begin
						tmp_q <= add_y[DW-1:0];
					end
					mc_q  <= mc_q << 1;
					ml_q  <= ml_q >> 1;
					cnt_q <= cnt_q + 1'b1;
				end
				SV_LD2: begin
					mc_q  <= tmp_q;
					ml_q  <= ent[2];
					cnt_q <= '0;
				end
				SV_MUL2: begin
					if (ml_q[0]) begin
						acc_q <= add_y[DW-1:0];
					end
					mc_q  <= mc_q << 1;
					ml_q  <= ml_q >> 1;
					cnt_q <= cnt_q + 1'b1;
				end
				SV_NEXT: begin
					if (term_q != 3'(NTERMS - 1)) begin
						term_q <= term_q + 3'd1;
					end else if (pass_q == 2'd0 && acc_q == '0) begin
						status_q <= ST_SING;
					end
				end
				SV_ABS: begin
					if (pass_q == 2'd0) begin
						dneg_q <= acc_q[DW-1];
						dabs_q <= acc_q[DW-1] ? add_y[DW-1:0] : acc_q;
						acc_q  <= '0;
						pass_q <= 2'd1;
						term_q <= '0;
					end else begin
						nneg_q   <= acc_q[DW-1];
						num_q    <= acc_q[DW-1] ? add_y[DW-1:0] : acc_q;
						rem_q    <= '0;
						q_q      <= '0;
						sticky_q <= 1'b0;
						cnt_q    <= '0;
					end
				end
				SV_DIV: begin
					rem_q    <= add_y[DW] ? add_y[DW-1:0] : r2;
					q_q      <= {q_q[Q_W-2:0], add_y[DW]};
					sticky_q <= sticky_q | q_q[Q_W-1];
					num_q    <= num_q << 1;
					cnt_q    <= cnt_q + 1'b1;
				end
				SV_RND: begin
					coef_q[pass_q - 2'd1] <= fin;
					pass_q <= pass_q + 2'd1;
					acc_q  <= '0;
					term_q <= '0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	assign coef0      = coef_q[0];
	assign coef1      = coef_q[1];
	assign coef2      = coef_q[2];
	assign span_start = lo_q;
	assign span_end   = hi_q;
	assign fit_status = status_q;

endmodule

/* hdl/quadratic_least_squares_fit.sv */
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Least-squares fit col = c2*row^2 + c1*row + c0 over a set of points.
// ----------------------------------------------------------------------------
// Usage: drive row, col, has_point and last with start; a beat is taken at
// an edge where start is high and busy is low. A point beat keeps busy high
// while one shared multiplier builds row^1..row^4 and the col*row^k
// moments, so the next point waits until that is done; an empty marker
// without last leaves busy low.
// A beat with last set runs the solve once accumulation is done: one
// bit-serial multiply/add unit forms four exact 3x3 determinants (six terms,
// each two bit-serial multiplies), and each coefficient comes from a
// restoring divide and a rounding step. A singular set ends after the first
// determinant; sets with no points or dropped points skip the solve.
// The result shows for exactly one cycle with done high; the receiver cannot
// stall it. Sums clear after each result. Reset clears all sums and the
// sequencer; busy is low after reset.
// ----------------------------------------------------------------------------
module quadratic_least_squares_fit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [qlsf_pkg::ROW_BITS-1:0]        row,
	input  logic [qlsf_pkg::COL_BITS-1:0]        col,
	input  logic                                 has_point,
	input  logic                                 last,
	output logic                                 done,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef0,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef1,
	output logic signed [qlsf_pkg::OUT_BITS-1:0] coef2,
	output logic [qlsf_pkg::ROW_BITS-1:0]        span_start,
	output logic [qlsf_pkg::ROW_BITS-1:0]        span_end,
	output logic [qlsf_pkg::STAT_BITS-1:0]       fit_status
);
	import qlsf_pkg::*;

	acc_sums_t sums;
	logic      take, last_q, go, solve_busy, clear;

	assign take = start && !busy;
	assign go   = last_q && sums.idle && !solve_busy;
	assign busy = !sums.idle || last_q || solve_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (go) begin
			last_q <= 1'b0;
		end else if (take && last) begin
			last_q <= 1'b1;
		end
	end

	qlsf_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.row       (row),
		.col       (col),
		.has_point (has_point),
		.clear     (clear),
		.sums      (sums)
	);

	qlsf_solve u_solve (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.sums       (sums),
		.busy       (solve_busy),
		.done       (done),
		.clear      (clear),
		.coef0      (coef0),
		.coef1      (coef1),
		.coef2      (coef2),
		.span_start (span_start),
		.span_end   (span_end),
		.fit_status (fit_status)
	);

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for quadratic_least_squares_fit. A queue of point beats, filled by
// directed sets (empty set, singular sets, extremes) and random sets, feeds a
// driver. A predictor keeps exact sums, solves the normal equations with wide
// integers, and the monitor checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	import qlsf_pkg::*;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0] uwide_t;

	typedef struct {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                has_point;
		logic                last;
	} beat_t;

	typedef struct {
		logic [OUT_BITS-1:0]  c0, c1, c2;
		logic [ROW_BITS-1:0]  lo, hi;
		logic [STAT_BITS-1:0] status;
	} fit_t;

	localparam int LIMIT = 40000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [ROW_BITS-1:0] row = '0;
	logic [COL_BITS-1:0] col = '0;
	logic has_point = 0;
	logic last = 0;
	logic busy, done;
	logic signed [OUT_BITS-1:0] coef0, coef1, coef2;
	logic [ROW_BITS-1:0] span_start, span_end;
	logic [STAT_BITS-1:0] fit_status;

	beat_t pending_q[$];
	fit_t fit_q[$];
	int errors = 0;
	int gap = 0;
	int cycles = 0;
	bit took = 0;

	// accumulated sums of the predictor
	int unsigned n_pts;
	logic [SUM_BITS-1:0] pw_sum [4];
	logic [MOM_BITS-1:0] mom_sum [3];
	logic [ROW_BITS-1:0] first_row, latest_row;
	logic dropped;

	always #2 clk = ~clk;

	quadratic_least_squares_fit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.row(row), .col(col), .has_point(has_point), .last(last),
		.done(done), .coef0(coef0), .coef1(coef1), .coef2(coef2),
		.span_start(span_start), .span_end(span_end), .fit_status(fit_status)
	);

	function automatic void clear_sums();
		n_pts = 0;
		for (int k = 0; k < 4; k++) pw_sum[k] = '0;
		for (int k = 0; k < 3; k++) mom_sum[k] = '0;
		first_row = '0;
		latest_row = '0;
		dropped = 0;
	endfunction

	function automatic wide_t det3(input wide_t m [9]);
		return m[0] * (m[4] * m[8] - m[5] * m[7])
			- m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
	endfunction

	function automatic logic [OUT_BITS-1:0] fixed_quotient(input wide_t num, input wide_t den);
		logic neg;
		uwide_t n, d, q, r;
		logic [63:0] mag, lim;
		neg = num[255] ^ den[255];
		n = num[255] ? -num : num;
		d = den[255] ? -den : den;
		n = n << FRAC_BITS;
		q = n / d;
		r = n % d;
		if ((r << 1) >= d) q = q + 1;
		lim = 64'd1 << (OUT_BITS - 1);
		if (q[255:64] != '0) return neg ? lim[OUT_BITS-1:0] : lim[OUT_BITS-1:0] - 1;
		mag = q[63:0];
		if (neg) return mag >= lim ? lim[OUT_BITS-1:0] : OUT_BITS'(64'd0 - mag);
		return mag >= lim ? lim[OUT_BITS-1:0] - 1 : mag[OUT_BITS-1:0];
	endfunction

	function automatic void predict_beat(input beat_t b);
		logic [63:0] p;
		fit_t f;
		wide_t s [5];
		wide_t m [9], mj [9];
		wide_t det;
		logic [OUT_BITS-1:0] cf [3];
		if (b.has_point) begin
			if (n_pts >= MAX_POINTS) begin
				dropped = 1;
			end else begin
				p = 64'(b.row);
				for (int k = 0; k < 4; k++) begin
					pw_sum[k] = pw_sum[k] + p[SUM_BITS-1:0];
					p = p * 64'(b.row);
				end
				p = 64'(b.col);
				for (int k = 0; k < 3; k++) begin
					mom_sum[k] = mom_sum[k] + p[MOM_BITS-1:0];
					p = p * 64'(b.row);
				end
				if (n_pts == 0) first_row = b.row;
				latest_row = b.row;
				n_pts++;
			end
		end
		if (!b.last) return;
		f = '{default: '0};
		if (n_pts == 0) begin
			f.status = ST_NOPTS;
		end else begin
			f.lo = first_row < latest_row ? first_row : latest_row;
			f.hi = first_row < latest_row ? latest_row : first_row;
			if (dropped) begin
				f.status = ST_DROP;
			end else begin
				s[0] = wide_t'(n_pts);
				for (int k = 0; k < 4; k++) s[k+1] = wide_t'(pw_sum[k]);
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) m[i*3+j] = s[i+j];
				det = det3(m);
				if (det == 0) begin
					f.status = ST_SING;
				end else begin
					f.status = ST_OK;
					for (int j = 0; j < 3; j++) begin
						mj = m;
						for (int i = 0; i < 3; i++) mj[i*3+j] = wide_t'(mom_sum[i]);
						cf[j] = fixed_quotient(det3(mj), det);
					end
					f.c0 = cf[0];
					f.c1 = cf[1];
					f.c2 = cf[2];
				end
			end
		end
		fit_q = {fit_q, f};
		clear_sums();
	endfunction

	task automatic check_field(input string name, input logic [OUT_BITS-1:0] e,
			input logic [OUT_BITS-1:0] a);
		if (e !== a) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	// monitor first, then take the beat accepted at this edge
	always @(posedge clk) begin
		fit_t f;
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb failed");
			$finish;
		end
		if (arst_n && done) begin
			if (fit_q.size() == 0) begin
				$display("%0t unexpected result, status %0d", $time, fit_status);
				errors++;
			end else begin
				f = fit_q.pop_front();
				check_field("coef0", f.c0, coef0);
				check_field("coef1", f.c1, coef1);
				check_field("coef2", f.c2, coef2);
				check_field("span_start", OUT_BITS'(f.lo), OUT_BITS'(span_start));
				check_field("span_end", OUT_BITS'(f.hi), OUT_BITS'(span_end));
				check_field("fit_status", OUT_BITS'(f.status), OUT_BITS'(fit_status));
			end
		end
		took = arst_n && start && !busy;
		if (took)
			predict_beat(pending_q.pop_front());
	end

	always @(negedge clk) begin
		if (took && pending_q.size() > 150 && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 11);
		if (gap > 0 || pending_q.size() == 0 || !arst_n) begin
			if (gap > 0) gap = gap - 1;
			start <= 0;
		end else begin
			start <= 1;
			row <= pending_q[0].row;
			col <= pending_q[0].col;
			has_point <= pending_q[0].has_point;
			last <= pending_q[0].last;
		end
	end

	task automatic add_beat(input int r, input int c, input bit hp, input bit lst);
		beat_t b;
		b.row = ROW_BITS'(r);
		b.col = COL_BITS'(c);
		b.has_point = hp;
		b.last = lst;
		pending_q = {pending_q, b};
	endtask

	task automatic add_random_set(inout int n_items);
		int kind, len, r0, r1;
		kind = $urandom_range(0, 9);
		len = (kind == 9) ? $urandom_range(0, 2) : $urandom_range(5, 20);
		r0 = $urandom_range(0, 1023);
		r1 = $urandom_range(0, 1023);
		for (int i = 0; i < len; i++) begin
			if (kind == 8)
				add_beat($urandom_range(0, 1) ? r0 : r1, $urandom_range(0, 2047), 1, 0);
			else if (kind == 7 && $urandom_range(0, 3) == 0)
				add_beat($urandom_range(0, 1023), $urandom_range(0, 2047), 0, 0);
			else
				add_beat($urandom_range(0, 1023), $urandom_range(0, 2047), 1, 0);
		end
		add_beat($urandom_range(0, 1023), $urandom_range(0, 2047),
			$urandom_range(0, 4) != 0, 1);
		n_items += len + 1;
	endtask

	initial begin
		int n_items;
		clear_sums();
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// empty set, then lone point, then two distinct rows only
		add_beat(5, 7, 0, 1);
		add_beat(1023, 2047, 1, 1);
		add_beat(3, 100, 1, 0);
		add_beat(900, 5, 1, 0);
		add_beat(3, 200, 1, 1);
		// extremes with an empty marker inside and an empty closing beat
		add_beat(1023, 2047, 1, 0);
		add_beat(0, 0, 1, 0);
		add_beat(0, 0, 0, 0);
		add_beat(512, 1024, 1, 0);
		add_beat(0, 0, 0, 1);
		// steep curve
		add_beat(0, 2047, 1, 0);
		add_beat(1, 0, 1, 0);
		add_beat(2, 2047, 1, 1);
		// exact parabola, all bits of row and col toggled
		add_beat(682, 341, 1, 0);
		add_beat(341, 1706, 1, 0);
		add_beat(10, 20, 1, 1);

		n_items = 16;
		while (n_items < 1950) add_random_set(n_items);

		wait (pending_q.size() == 0);
		wait (fit_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/qlsf_pkg.sv
hdl/qlsf_accum.sv
hdl/qlsf_solve.sv
hdl/quadratic_least_squares_fit.sv
test/tb.sv
